// ===== sv/utf8d_pkg.sv =====
package utf8d_pkg;

  localparam int unsigned CpWidth = 21;
  localparam int unsigned ByteWidth = 8;
  localparam int unsigned LeftWidth = 3;

  localparam logic [7:0] AsciiLimit = 8'h80;
  localparam logic [7:0] Lead2Mask = 8'hE0;
  localparam logic [7:0] Lead2Code = 8'hC0;
  localparam logic [7:0] Lead3Mask = 8'hF0;
  localparam logic [7:0] Lead3Code = 8'hE0;
  localparam logic [7:0] Lead4Mask = 8'hF8;
  localparam logic [7:0] Lead4Code = 8'hF0;
  localparam logic [7:0] ContMask = 8'hC0;
  localparam logic [7:0] ContCode = 8'h80;
  localparam logic [7:0] Bits2Mask = 8'h1F;
  localparam logic [7:0] Bits3Mask = 8'h0F;
  localparam logic [7:0] Bits4Mask = 8'h07;

  typedef struct packed {
    logic [CpWidth-1:0] accumulator;
    logic [1:0]         pending_count;
    logic               draining;
  } dec_state_t;

  typedef struct packed {
    logic               valid;
    logic [CpWidth-1:0] code_point;
  } dec_result_t;

endpackage

// ===== sv/utf8_to_codepoint_decoder_unit.sv =====
// Streaming UTF-8 decoder: one byte enters per beat together with the number of bytes
// left in its string (saturated at 4), and a 21-bit code point leaves when a sequence
// completes. Each byte passes an input register, combinational decode logic and a result
// register, so the block takes one byte every cycle while the output is not stalled, and
// a code point leaves the result register after its last byte has passed the input register. Invalid leads are
// skipped, a bad continuation byte restarts decoding at that byte, and a lead that needs
// more bytes than remain discards the rest of the string. No overlong, surrogate or
// range checks are made.
module utf8_to_codepoint_decoder_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [utf8d_pkg::ByteWidth-1:0]    data_byte,
  input  logic [utf8d_pkg::LeftWidth-1:0]    bytes_left,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [utf8d_pkg::CpWidth-1:0]      code_point
);

  logic                               hold_valid;
  logic [utf8d_pkg::ByteWidth-1:0]    hold_byte;
  logic [utf8d_pkg::LeftWidth-1:0]    hold_left;
  utf8d_pkg::dec_state_t              state;
  utf8d_pkg::dec_state_t              state_next;
  utf8d_pkg::dec_result_t             result;
  logic                               advance;
  logic                               out_free;

  utf8d_step u_step (
    .state      (state),
    .data_byte  (hold_byte),
    .bytes_left (hold_left),
    .state_next (state_next),
    .result     (result)
  );

  assign out_free = !out_valid || !out_stall;
  assign advance = hold_valid && out_free;
  assign in_stall = hold_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!in_stall) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      hold_byte <= data_byte;
      hold_left <= bytes_left;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= advance && result.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result.valid) begin
      code_point <= result.code_point;
    end
  end

endmodule

// ===== sv/utf8d_step.sv =====
module utf8d_step (
  input  utf8d_pkg::dec_state_t                  state,
  input  logic [utf8d_pkg::ByteWidth-1:0]        data_byte,
  input  logic [utf8d_pkg::LeftWidth-1:0]        bytes_left,
  output utf8d_pkg::dec_state_t                  state_next,
  output utf8d_pkg::dec_result_t                 result
);

  logic [2:0]                       left;
  logic [2:0]                       need;
  logic [utf8d_pkg::CpWidth-1:0]    bits;
  logic                             lead_ok;
  logic                             is_cont;
  logic [utf8d_pkg::CpWidth-1:0]    acc_shift;
  logic [1:0]                       pend_dec;

  always_comb begin
    if (bytes_left == 3'd0) begin
      left = 3'd1;
    end else if (bytes_left > 3'd4) begin
      left = 3'd4;
    end else begin
      left = bytes_left;
    end
  end

  always_comb begin
    lead_ok = 1'b1;
    need = 3'd1;
    bits = '0;
    priority if (data_byte < utf8d_pkg::AsciiLimit) begin
      need = 3'd1;
      bits = {13'd0, data_byte};
    end else if ((data_byte & utf8d_pkg::Lead2Mask) == utf8d_pkg::Lead2Code) begin
      need = 3'd2;
      bits = {13'd0, data_byte & utf8d_pkg::Bits2Mask};
    end else if ((data_byte & utf8d_pkg::Lead3Mask) == utf8d_pkg::Lead3Code) begin
      need = 3'd3;
      bits = {13'd0, data_byte & utf8d_pkg::Bits3Mask};
    end else if ((data_byte & utf8d_pkg::Lead4Mask) == utf8d_pkg::Lead4Code) begin
      need = 3'd4;
      bits = {13'd0, data_byte & utf8d_pkg::Bits4Mask};
    end else begin
      lead_ok = 1'b0;
    end
  end

  assign is_cont = (data_byte & utf8d_pkg::ContMask) == utf8d_pkg::ContCode;
  assign acc_shift = {state.accumulator[utf8d_pkg::CpWidth-7:0], data_byte[5:0]};
  assign pend_dec = state.pending_count - 2'd1;

  always_comb begin
    state_next = state;
    result.valid = 1'b0;
    result.code_point = acc_shift;
    if (state.draining) begin
      if (left == 3'd1) begin
        state_next.draining = 1'b0;
      end
    end else if ((state.pending_count != 2'd0) && is_cont) begin
      state_next.accumulator = acc_shift;
      state_next.pending_count = pend_dec;
      if (pend_dec == 2'd0) begin
        result.valid = 1'b1;
      end else if (left == 3'd1) begin
        state_next.pending_count = 2'd0;
      end
    end else begin
      // A broken sequence is dropped and this byte is treated as a lead.
      state_next.pending_count = 2'd0;
      if (lead_ok) begin
        if (need > left) begin
          state_next.draining = (left != 3'd1);
        end else if (need == 3'd1) begin
          result.valid = 1'b1;
          result.code_point = bits;
        end else begin
          state_next.accumulator = bits;
          state_next.pending_count = 2'(need - 3'd1);
        end
      end
    end
  end

endmodule
